### hw/rtl/prpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prpb_pkg;

   localparam int STORE_DEPTH_DEFAULT = 4096;
   localparam int QUEUE_DEPTH         = 4;

   localparam int BUF_WORDS_W = 13;
   localparam int MODE_W      = 2;
   localparam int GAIN_W      = 8;
   localparam int CSR_W       = 13;
   localparam int SAMPLE_W    = 16;
   localparam int LEVEL_W     = 16;
   localparam int WORD_W      = 32;
   localparam int REJECT_W    = 16;
   localparam int FREE_W      = 13;
   localparam int PLAYED_W    = 32;
   localparam int PROD_W      = 26;
   localparam int DAC_LEVEL_W = 11;

   localparam logic [BUF_WORDS_W-1:0] BUFFER_WORDS_RESET = 13'd4096;
   localparam logic [GAIN_W-1:0]      VOLUME_GAIN_RESET  = 8'd255;
   localparam logic [LEVEL_W-1:0]     IDLE_LEVEL         = 16'd1024;
   localparam logic [REJECT_W-1:0]    REJECT_MAX         = 16'hFFFF;
   // half-scale offset ahead of the >>13 (mono) and >>14 (stereo) scaling
   localparam logic [PROD_W-1:0]      MONO_BIAS          = 26'd8388608;
   localparam logic [PROD_W-1:0]      STEREO_BIAS        = 26'd16777216;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_TICK  = 2'd1,
      OP_START = 2'd2,
      OP_IDLE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_RAW    = 2'd0,
      MODE_MONO   = 2'd1,
      MODE_STEREO = 2'd2,
      MODE_HOLD   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_BUFFER_WORDS = 2'd0,
      REG_SAMPLE_MODE  = 2'd1,
      REG_VOLUME_GAIN  = 2'd2
   } csr_index_type;

   typedef enum logic {
      BACK_CLEAR = 1'b0,
      BACK_RUN   = 1'b1
   } back_state_type;

   typedef struct packed {
      logic [1:0]                 opcode;
      logic signed [SAMPLE_W-1:0] sample_a;
      logic signed [SAMPLE_W-1:0] sample_b;
      logic                       last_frame;
   } req_type;

   typedef struct packed {
      logic                  frame_accepted;
      logic [REJECT_W-1:0]   rejected_in_call;
      logic [LEVEL_W-1:0]    level_low;
      logic [LEVEL_W-1:0]    level_high;
      logic                  level_valid;
      logic [FREE_W-1:0]     free_words;
      logic [PLAYED_W-1:0]   played_total;
   } rsp_type;

   typedef struct packed {
      opcode_type          op;
      logic [WORD_W-1:0]   word;
      logic                store_en;
      logic                last_frame;
   } job_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

`default_nettype wire

### hw/rtl/pcm_to_pwm_ring_buffer.sv
// Path: an item passes the front register and the queue to the back-end result register.
// Throughput: one item per cycle while busy is low; clearing or a full queue raise busy.
// Start: from its result cycle busy holds while 1024 is swept into every store word.
// Reset: synchronous, active high; busy holds for a clearing pass of the store after it.
// Results are strobed for one cycle and the receiver cannot stall them.
`timescale 1ns / 1ps
`default_nettype none

module pcm_to_pwm_ring_buffer
   import prpb_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire req_type          req_data,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data,
   input  wire logic             csr_write_en,
   input  wire logic [1:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_W = CNT_W + 1;

   // configuration registers
   logic [BUF_WORDS_W-1:0] buffer_words_ff, buffer_words_in;
   logic [MODE_W-1:0]      sample_mode_ff, sample_mode_in;
   logic [GAIN_W-1:0]      volume_gain_ff, volume_gain_in;

   logic                   accept;
   logic                   front_valid;
   job_type                front_job;
   logic                   queue_not_empty;
   logic [CNT_W-1:0]       queue_count;
   job_type                queue_job;
   logic                   back_pop;
   back_status_type        back_status;
   logic [OCC_W-1:0]       occupancy;

   // write decode; an index beyond the list is dropped
   always_comb begin
      buffer_words_in = buffer_words_ff;
      sample_mode_in  = sample_mode_ff;
      volume_gain_in  = volume_gain_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_BUFFER_WORDS: buffer_words_in = csr_data[BUF_WORDS_W-1:0];
            REG_SAMPLE_MODE:  sample_mode_in  = csr_data[MODE_W-1:0];
            REG_VOLUME_GAIN:  volume_gain_in  = csr_data[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_words_ff <= BUFFER_WORDS_RESET;
         sample_mode_ff  <= MODE_RAW;
         volume_gain_ff  <= VOLUME_GAIN_RESET;
      end else begin
         buffer_words_ff <= buffer_words_in;
         sample_mode_ff  <= sample_mode_in;
         volume_gain_ff  <= volume_gain_in;
      end
   end

   // Count the item held in the front stage as well as the queued ones, so
   // the queue can never overflow however long the back end is held up.
   assign occupancy = OCC_W'(queue_count) + OCC_W'(front_valid);
   assign busy      = back_status.clearing || (occupancy >= OCC_W'(QUEUE_DEPTH));
   assign accept    = start && !busy;

   // front: take the transfer in, scale and reduce the samples
   prpb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_data    (req_data),
      .sample_mode (sample_mode_ff),
      .volume_gain (volume_gain_ff),
      .push_valid  (front_valid),
      .push_job    (front_job)
   );

   // decoupling queue between classification and store access
   prpb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_job  (front_job),
      .pop       (back_pop),
      .pop_job   (queue_job),
      .not_empty (queue_not_empty),
      .count     (queue_count)
   );

   // back: pointers, fill count, counters, level store and the result
   prpb_back #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (queue_not_empty),
      .job          (queue_job),
      .buffer_words (buffer_words_ff),
      .job_pop      (back_pop),
      .status       (back_status),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire

### hw/rtl/prpb_front.sv
`timescale 1ns / 1ps
`default_nettype none

module prpb_front
   import prpb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire req_type           req_data,
   input  wire logic [MODE_W-1:0] sample_mode,
   input  wire logic [GAIN_W-1:0] volume_gain,
   output logic                   push_valid,
   output job_type                push_job
);

   logic                     valid_ff, valid_in;
   opcode_type               op_ff;
   mode_type                 mode_ff;
   logic                     last_ff;
   logic [WORD_W-1:0]        raw_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   logic signed [SAMPLE_W:0] operand;
   logic signed [GAIN_W:0]   gain_s;
   logic [PROD_W-1:0]        biased;
   logic [DAC_LEVEL_W-1:0]   dac_level;
   logic [LEVEL_W-1:0]       level;

   // mix the pair in stereo mode, then one signed multiply by the gain
   always_comb begin
      if (mode_type'(sample_mode) == MODE_STEREO) begin
         operand = {req_data.sample_a[SAMPLE_W-1], req_data.sample_a}
                 + {req_data.sample_b[SAMPLE_W-1], req_data.sample_b};
      end else begin
         operand = {req_data.sample_a[SAMPLE_W-1], req_data.sample_a};
      end
      gain_s  = {1'b0, volume_gain};
      prod_in = PROD_W'(operand) * PROD_W'(gain_s);
   end

   assign valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= opcode_type'(req_data.opcode);
         mode_ff <= mode_type'(sample_mode);
         last_ff <= req_data.last_frame;
         raw_ff  <= {req_data.sample_b, req_data.sample_a};
         prod_ff <= prod_in;
      end
   end

   // add half scale and drop to the 11-bit DAC level
   always_comb begin
      if (mode_ff == MODE_STEREO) begin
         biased    = $unsigned(prod_ff) + STEREO_BIAS;
         dac_level = biased[DAC_LEVEL_W+13:14];
      end else begin
         biased    = $unsigned(prod_ff) + MONO_BIAS;
         dac_level = biased[DAC_LEVEL_W+12:13];
      end
      level = LEVEL_W'(dac_level);
   end

   always_comb begin
      push_job.op         = op_ff;
      push_job.last_frame = last_ff;
      case (mode_ff)
         MODE_RAW: begin
            push_job.word     = raw_ff;
            push_job.store_en = 1'b1;
         end
         MODE_MONO, MODE_STEREO: begin
            push_job.word     = {level, level};
            push_job.store_en = 1'b1;
         end
         default: begin
            push_job.word     = raw_ff;
            push_job.store_en = 1'b0;
         end
      endcase
   end

   assign push_valid = valid_ff;

endmodule

`default_nettype wire

### hw/rtl/prpb_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module prpb_queue
   import prpb_pkg::*;
#(
   localparam int QA_W  = $clog2(QUEUE_DEPTH),
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire job_type          push_job,
   input  wire logic             pop,
   output job_type               pop_job,
   output logic                  not_empty,
   output logic [CNT_W-1:0]      count
);

   job_type            entry_ff [QUEUE_DEPTH];
   logic [QA_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QA_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [QA_W-1:0] advance(input logic [QA_W-1:0] p);
      if (p == QA_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + QA_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? advance(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? advance(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign pop_job   = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

`default_nettype wire

### hw/rtl/prpb_back.sv
`timescale 1ns / 1ps
`default_nettype none

module prpb_back
   import prpb_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   job_valid,
   input  wire job_type                job,
   input  wire logic [BUF_WORDS_W-1:0] buffer_words,
   output logic                        job_pop,
   output back_status_type             status,
   output logic                        rsp_strobe,
   output rsp_type                     rsp_data
);

   localparam int PTR_W = $clog2(STORE_DEPTH);
   localparam int LEN_W = $clog2(STORE_DEPTH + 1);
   localparam int CMP_W = (LEN_W > BUF_WORDS_W) ? LEN_W : BUF_WORDS_W;

   back_state_type       state_ff, state_in;
   logic [PTR_W-1:0]     sweep_addr_ff, sweep_addr_in;
   logic [PTR_W-1:0]     wp_ff, wp_in;
   logic [PTR_W-1:0]     rp_ff, rp_in;
   logic [LEN_W-1:0]     fill_ff, fill_in;
   logic [PLAYED_W-1:0]  play_ff, play_in;
   logic [REJECT_W-1:0]  reject_ff, reject_in;

   logic                 res_valid_ff, res_valid_in;
   logic                 res_accepted_ff, res_accepted_in;
   logic                 res_level_valid_ff, res_level_valid_in;
   logic [REJECT_W-1:0]  res_reject_ff, res_reject_in;

   logic [WORD_W-1:0]    store_mem [STORE_DEPTH];
   logic [WORD_W-1:0]    rd_data_ff;
   logic                 mem_we, mem_re;
   logic [PTR_W-1:0]     mem_waddr;
   logic [WORD_W-1:0]    mem_wdata;

   logic [CMP_W-1:0]     words_ext;
   logic [LEN_W-1:0]     len;
   logic                 clearing;
   logic                 sweep_done;
   logic [LEN_W-1:0]     free_len;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
                                                 input logic [LEN_W-1:0] n_len);
      logic [LEN_W-1:0] n;
      n = LEN_W'(p) + LEN_W'(1);
      if (n >= n_len) begin
         return '0;
      end
      return n[PTR_W-1:0];
   endfunction

   // clamp the configured length into 1..STORE_DEPTH
   always_comb begin
      words_ext = CMP_W'(buffer_words);
      if (words_ext == '0) begin
         len = LEN_W'(1);
      end else if (words_ext > CMP_W'(STORE_DEPTH)) begin
         len = LEN_W'(STORE_DEPTH);
      end else begin
         len = LEN_W'(words_ext);
      end
   end

   assign sweep_done = (sweep_addr_ff == PTR_W'(STORE_DEPTH - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_CLEAR: begin
            if (sweep_done) begin
               state_in = BACK_RUN;
            end
         end
         BACK_RUN: begin
            if (job_valid && job.op == OP_START) begin
               state_in = BACK_CLEAR;
            end
         end
         default: begin
            state_in = BACK_CLEAR;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      clearing = 1'b0;
      job_pop  = 1'b0;
      case (state_ff)
         BACK_CLEAR: begin
            clearing = 1'b1;
         end
         BACK_RUN: begin
            job_pop = job_valid;
         end
         default: begin
            clearing = 1'b1;
         end
      endcase
   end

   assign sweep_addr_in = clearing ? sweep_addr_ff + PTR_W'(1) : '0;

   always_comb begin
      wp_in              = wp_ff;
      rp_in              = rp_ff;
      fill_in            = fill_ff;
      play_in            = play_ff;
      reject_in          = reject_ff;
      res_valid_in       = job_pop;
      res_accepted_in    = 1'b0;
      res_level_valid_in = 1'b0;
      res_reject_in      = reject_ff;
      mem_we             = clearing;
      mem_re             = 1'b0;
      mem_waddr          = sweep_addr_ff;
      mem_wdata          = {IDLE_LEVEL, IDLE_LEVEL};
      if (job_pop) begin
         case (job.op)
            OP_PUSH: begin
               if (fill_ff < len) begin
                  mem_we          = job.store_en;
                  mem_waddr       = wp_ff;
                  mem_wdata       = job.word;
                  wp_in           = next_ptr(wp_ff, len);
                  fill_in         = fill_ff + LEN_W'(1);
                  res_accepted_in = 1'b1;
               end else if (reject_ff != REJECT_MAX) begin
                  reject_in = reject_ff + REJECT_W'(1);
               end
               res_reject_in = reject_in;
               if (job.last_frame) begin
                  reject_in = '0;
               end
            end
            OP_TICK: begin
               if (fill_ff != '0) begin
                  mem_re             = 1'b1;
                  rp_in              = next_ptr(rp_ff, len);
                  fill_in            = fill_ff - LEN_W'(1);
                  play_in            = play_ff + PLAYED_W'(1);
                  res_level_valid_in = 1'b1;
               end
            end
            OP_START: begin
               wp_in         = '0;
               rp_in         = '0;
               fill_in       = '0;
               play_in       = '0;
               reject_in     = '0;
               res_reject_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BACK_CLEAR;
         sweep_addr_ff <= '0;
         wp_ff         <= '0;
         rp_ff         <= '0;
         fill_ff       <= '0;
         play_ff       <= '0;
         reject_ff     <= '0;
         res_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
         wp_ff         <= wp_in;
         rp_ff         <= rp_in;
         fill_ff       <= fill_in;
         play_ff       <= play_in;
         reject_ff     <= reject_in;
         res_valid_ff  <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_accepted_ff    <= res_accepted_in;
      res_level_valid_ff <= res_level_valid_in;
      res_reject_ff      <= res_reject_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= store_mem[rp_ff];
      end
   end

   // fill and play count already hold the state left by the item on show
   assign free_len = (fill_ff < len) ? len - fill_ff : '0;

   always_comb begin
      rsp_data.frame_accepted   = res_accepted_ff;
      rsp_data.rejected_in_call = res_reject_ff;
      rsp_data.level_valid      = res_level_valid_ff;
      rsp_data.level_low        = res_level_valid_ff ? rd_data_ff[LEVEL_W-1:0] : '0;
      rsp_data.level_high       = res_level_valid_ff ? rd_data_ff[WORD_W-1:LEVEL_W] : '0;
      rsp_data.free_words       = FREE_W'(free_len);
      rsp_data.played_total     = play_ff;
   end

   assign rsp_strobe      = res_valid_ff;
   assign status.clearing = clearing;

endmodule

`default_nettype wire
